FILE: src/ialu_pkg.sv
// Shared types and constants for the integer ALU with primality test.
// Used by ialu_ctrl, ialu_dp and integer_alu_with_prime_test_top; no dependencies.
package ialu_pkg;

    // Field widths.
    localparam int DATA_W  = 32;
    localparam int ACT_W   = 3;
    localparam int ERR_W   = 2;

    // The divider resolves one quotient bit per cycle.
    localparam int DIV_STEPS = DATA_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Trial divisor and its running square.
    localparam int TRIAL_W = 16;
    localparam int SQ_W    = DATA_W + 1;

    // Action codes.
    typedef enum logic [ACT_W-1:0] {
        ACT_ADD   = 3'd0,
        ACT_SUB   = 3'd1,
        ACT_MUL   = 3'd2,
        ACT_DIV   = 3'd3,
        ACT_PRIME = 3'd4
    } act_t;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_OK      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_ACTION  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_DIVZERO = 2'd2;

    // Source of the result register.
    typedef enum logic [2:0] {
        RES_NONE = 3'd0,
        RES_ALU  = 3'd1,
        RES_QUO  = 3'd2,
        RES_ONE  = 3'd3,
        RES_ZERO = 3'd4
    } res_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;
        logic     div_start;
        logic     div_prime;
        logic     div_step;
        logic     p_init;
        logic     p_next;
        logic     out_load;
        res_sel_t res_sel;
        act_t     op;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic b_zero;
        logic a_small;
        logic sq_gt_n;
        logic rem_zero;
        logic cnt_last;
    } sts_t;

endpackage

FILE: src/integer_alu_with_prime_test_top.sv
// Top level of the integer ALU with trial-division primality test.
// Depends on ialu_pkg, ialu_ctrl and ialu_dp.
//
//  Channel  Handshake             Beat contents
//  -------  --------------------  -------------------------------------
//  in       in_valid / in_ready   action, operand_a, operand_b
//  out      out_valid / out_ready value, error
//
// One item is in work at a time. Add, subtract, multiply, invalid actions and a
// zero divisor go from the input beat through the operand and result registers to the
// output register; divide first runs the divider that resolves one quotient bit per cycle.
// The prime test runs one division per trial divisor and ends when a divisor leaves
// no remainder or the square of the divisor exceeds A; values up to 2 skip the search.
// rst_n clears the controller and the output valid at once; no clearing pass.
// A stalled output beat stalls the block only when the next result is ready.
module integer_alu_with_prime_test_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [ialu_pkg::ACT_W-1:0]         action,
    input  logic signed [ialu_pkg::DATA_W-1:0] operand_a,
    input  logic signed [ialu_pkg::DATA_W-1:0] operand_b,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [ialu_pkg::DATA_W-1:0] value,
    output logic [ialu_pkg::ERR_W-1:0]         error
);
    import ialu_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Controller.
    ialu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Datapath.
    ialu_dp u_dp (
        .clk       (clk),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .cmd       (cmd),
        .sts       (sts),
        .value     (value),
        .error     (error)
    );

    // Only one item is in work: an accepted beat closes the input for the next cycle.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while an item was in work");

    // A result beat with an error carries a zero value.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (error == ERR_ACTION || error == ERR_DIVZERO) |-> value == '0)
        else $error("error result with non-zero value");

    // The output register is only reloaded when empty or being drained.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !out_valid || out_ready)
        else $error("output overwritten while stalled");

    // The divider is only started with a non-zero divisor.
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start && !cmd.div_prime |-> !sts.b_zero)
        else $error("divider started with zero divisor");

endmodule

FILE: src/ialu_ctrl.sv
// Controller state machine for the integer ALU with primality test.
// Depends on ialu_pkg; drives ialu_dp through cmd_t and reads sts_t.
module ialu_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ialu_pkg::ACT_W-1:0]    action,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ialu_pkg::cmd_t                cmd,
    input  ialu_pkg::sts_t                sts
);
    import ialu_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_ALU  = 6'b000010,
        S_PCHK = 6'b000100,
        S_DIV  = 6'b001000,
        S_DFIN = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    act_t   act_reg, act_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and command decode.
    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.res_sel    = RES_NONE;
        cmd.op         = act_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    act_next   = act_t'(action);
                    state_next = S_ALU;
                end
            end
            S_ALU:
            begin
                priority if (act_reg == ACT_DIV && !sts.b_zero)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else if (act_reg == ACT_PRIME && sts.a_small)
                begin
                    cmd.res_sel = RES_ONE;
                    state_next  = S_DONE;
                end
                else if (act_reg == ACT_PRIME)
                begin
                    cmd.p_init = 1'b1;
                    state_next = S_PCHK;
                end
                else
                begin
                    cmd.res_sel = RES_ALU;
                    state_next  = S_DONE;
                end
            end
            S_PCHK:
            begin
                // Stop once the trial divisor squared exceeds the candidate.
                if (sts.sq_gt_n)
                begin
                    cmd.res_sel = RES_ONE;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_prime = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.cnt_last)
                begin
                    state_next = S_DFIN;
                end
            end
            S_DFIN:
            begin
                priority if (act_reg == ACT_PRIME && sts.rem_zero)
                begin
                    cmd.res_sel = RES_ZERO;
                    state_next  = S_DONE;
                end
                else if (act_reg == ACT_PRIME)
                begin
                    cmd.p_next = 1'b1;
                    state_next = S_PCHK;
                end
                else
                begin
                    cmd.res_sel = RES_QUO;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                // Move the result into the output register once it is free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            act_reg       <= ACT_ADD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            act_reg       <= act_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: src/ialu_dp.sv
// Datapath for the integer ALU: operand, result and output registers, a
// bit-serial restoring divider and the trial-division counters. Depends on ialu_pkg.
module ialu_dp (
    input  logic                              clk,
    input  logic signed [ialu_pkg::DATA_W-1:0] operand_a,
    input  logic signed [ialu_pkg::DATA_W-1:0] operand_b,
    input  ialu_pkg::cmd_t                    cmd,
    output ialu_pkg::sts_t                    sts,
    output logic signed [ialu_pkg::DATA_W-1:0] value,
    output logic [ialu_pkg::ERR_W-1:0]        error
);
    import ialu_pkg::*;

    // Magnitude of a two's complement word, as an unsigned pattern.
    function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] x);
        mag = x[DATA_W-1] ? (~x + 1'b1) : x;
    endfunction

    logic [DATA_W-1:0]  a_reg, b_reg;
    logic [DATA_W-1:0]  res_reg, res_next;
    logic [ERR_W-1:0]   err_reg, err_next;
    logic [DATA_W-1:0]  rem_reg, rem_next;
    logic [DATA_W-1:0]  quo_reg, quo_next;
    logic [DATA_W-1:0]  dsr_reg, dsr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [TRIAL_W-1:0] i_reg, i_next;
    logic [SQ_W-1:0]    sq_reg, sq_next;
    logic [DATA_W-1:0]  value_reg;
    logic [ERR_W-1:0]   error_reg;

    logic [DATA_W-1:0]  alu_val;
    logic [ERR_W-1:0]   alu_err;
    logic [DATA_W:0]    trial;
    logic [DATA_W-1:0]  quo_signed;

    // Combinational results of the operations that need no divider, with their error codes.
    always_comb
    begin
        alu_val = '0;
        alu_err = ERR_OK;
        unique case (cmd.op)
            ACT_ADD:   alu_val = a_reg + b_reg;
            ACT_SUB:   alu_val = a_reg - b_reg;
            ACT_MUL:   alu_val = a_reg * b_reg;
            ACT_DIV:   alu_err = ERR_DIVZERO;
            ACT_PRIME: alu_val = '0;
            default:   alu_err = ERR_ACTION;
        endcase
    end

    // One restoring division step: shift in the next dividend bit and try a subtract.
    assign trial      = {rem_reg, quo_reg[DATA_W-1]} - {1'b0, dsr_reg};
    assign quo_signed = (a_reg[DATA_W-1] ^ b_reg[DATA_W-1]) ? (~quo_reg + 1'b1) : quo_reg;

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        if (cmd.div_start)
        begin
            rem_next = '0;
            cnt_next = '0;
            quo_next = cmd.div_prime ? a_reg : mag(a_reg);
            dsr_next = cmd.div_prime ? DATA_W'(i_reg) : mag(b_reg);
        end
        else if (cmd.div_step)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (!trial[DATA_W])
            begin
                rem_next = trial[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[DATA_W-2:0], quo_reg[DATA_W-1]};
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
        end
    end

    // Trial divisor and its square, advanced by (i+1)^2 = i^2 + 2i + 1.
    always_comb
    begin
        i_next  = i_reg;
        sq_next = sq_reg;
        if (cmd.p_init)
        begin
            i_next  = TRIAL_W'(2);
            sq_next = SQ_W'(4);
        end
        else if (cmd.p_next)
        begin
            i_next  = i_reg + 1'b1;
            sq_next = sq_reg + SQ_W'({i_reg, 1'b1});
        end
    end

    // Result register source.
    always_comb
    begin
        res_next = res_reg;
        err_next = err_reg;
        unique case (cmd.res_sel)
            RES_NONE: ;
            RES_ALU:
            begin
                res_next = alu_val;
                err_next = alu_err;
            end
            RES_QUO:
            begin
                res_next = quo_signed;
                err_next = ERR_OK;
            end
            RES_ONE:
            begin
                res_next = DATA_W'(1);
                err_next = ERR_OK;
            end
            RES_ZERO:
            begin
                res_next = '0;
                err_next = ERR_OK;
            end
            default: ;
        endcase
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg <= operand_a;
            b_reg <= operand_b;
        end
        res_reg <= res_next;
        err_reg <= err_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        cnt_reg <= cnt_next;
        i_reg   <= i_next;
        sq_reg  <= sq_next;
        if (cmd.out_load)
        begin
            value_reg <= res_reg;
            error_reg <= err_reg;
        end
    end

    // Status back to the controller.
    assign sts.b_zero   = (b_reg == '0);
    assign sts.a_small  = a_reg[DATA_W-1] || (a_reg[DATA_W-2:0] <= (DATA_W-1)'(2));
    assign sts.sq_gt_n  = (sq_reg > {1'b0, a_reg});
    assign sts.rem_zero = (rem_reg == '0);
    assign sts.cnt_last = (cnt_reg == CNT_W'(DIV_STEPS - 1));

    assign value = value_reg;
    assign error = error_reg;

endmodule
